@@ src/smeu_pkg.sv @@
// Package for the stack machine execute unit: payload types, opcodes,
// console actions, error codes and controller states. No dependencies.
package smeu_pkg;

	localparam int DataDepthDef   = 256;
	localparam int ReturnDepthDef = 64;
	localparam int VarCountDef    = 64;

	typedef enum logic [4:0] {
		OP_PUSH = 5'd0, OP_NOP = 5'd1, OP_JUMP = 5'd2, OP_JB = 5'd3, OP_JA = 5'd4,
		OP_JBE = 5'd5, OP_JAE = 5'd6, OP_JE = 5'd7, OP_JNE = 5'd8, OP_CALL = 5'd9,
		OP_RET = 5'd10, OP_ADD = 5'd11, OP_SUB = 5'd12, OP_MUL = 5'd13,
		OP_DIV = 5'd14, OP_TOP = 5'd15, OP_DUP = 5'd16, OP_CLEAR = 5'd17,
		OP_POP = 5'd18, OP_POPTO = 5'd19, OP_PUSHFROM = 5'd20, OP_GE = 5'd21,
		OP_LE = 5'd22, OP_GT = 5'd23, OP_LT = 5'd24, OP_EQ = 5'd25, OP_NE = 5'd26,
		OP_PRINT = 5'd27, OP_NEWLINE = 5'd28, OP_SPACE = 5'd29, OP_CLS = 5'd30,
		OP_GETCH = 5'd31
	} opcode_t;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0, ACT_VALUE = 3'd1, ACT_TEXT = 3'd2, ACT_NEWLINE = 3'd3,
		ACT_SPACE = 3'd4, ACT_CLS = 3'd5, ACT_KEY = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2, ERR_DIV0 = 3'd3,
		ERR_RET_EMPTY = 3'd4, ERR_RET_FULL = 3'd5
	} error_t;

	typedef struct packed {
		logic [4:0]         kind;
		logic signed [31:0] immediate;
		logic [15:0]        target;
		logic [5:0]         var_index;
		logic [15:0]        text_ref;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic               halted;
		logic [2:0]         action;
		logic signed [31:0] value;
		logic [15:0]        text_out;
		logic [2:0]         error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_DIV_WAIT, ST_WRITE, ST_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;       // capture input item, start stack reads
		logic read_n;     // read state: latch top, read next below
		logic exec;       // decide and compute
		logic div_start;
		logic commit;     // write state and build result
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_div;     // item needs the divider
		logic div_done;
	} stat_t;

endpackage

@@ src/smeu_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module smeu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q;
	logic [32:0] trial;

	// One restoring subtract step.
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = !busy_q && !start;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

@@ src/smeu_datapath.sv @@
// Datapath: pc, stacks, variable file, result register.
// Depends on smeu_pkg and smeu_div.
module smeu_datapath #(
	parameter int DATA_DEPTH   = smeu_pkg::DataDepthDef,
	parameter int RETURN_DEPTH = smeu_pkg::ReturnDepthDef,
	parameter int VAR_COUNT    = smeu_pkg::VarCountDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smeu_pkg::cmd_t     cmd,
	output smeu_pkg::stat_t    stat,
	input  smeu_pkg::in_item_t in_item,
	input  logic [15:0]        program_length,
	output smeu_pkg::out_item_t out_item
);
	import smeu_pkg::*;

	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int RAW = $clog2(RETURN_DEPTH);
	localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

	logic [31:0] dstk [DATA_DEPTH];
	logic [15:0] rstk [RETURN_DEPTH];
	logic [31:0] vars [VAR_COUNT];
	logic [VAR_COUNT-1:0] vvalid_q;

	logic [15:0]  pc_q;
	logic [DAW:0] dcnt_q;
	logic [RAW:0] rcnt_q;
	in_item_t     item_q;
	logic [31:0]  rd_q, t_q, n_q, var_q, res_q;
	logic [15:0]  ret_q;
	logic         vhit_q;
	error_t       err_q;
	logic         jump_q, wr_push_q, wr_bin_q, pop_q, popto_q, call_q, ret_op_q;
	logic         clear_q;
	out_item_t    out_q;

	logic [DAW-1:0] rd_addr;
	logic [31:0]    quo;
	logic           div_done;
	logic           vin;
	logic [VAW-1:0] vaddr;

	assign vin   = 32'(item_q.var_index) < VAR_COUNT;
	assign vaddr = VAW'(item_q.var_index);

	// Data stack read address: top on load, next below otherwise.
	always_comb begin
		if (cmd.load) rd_addr = DAW'(dcnt_q - 1'b1);
		else          rd_addr = DAW'(dcnt_q - 2'd2);
	end

	always_ff @(posedge clk) begin
		rd_q <= dstk[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.read_n) begin
			t_q   <= rd_q;
			ret_q <= rstk[RAW'(rcnt_q - 1'b1)];
			var_q <= vars[vaddr];
			vhit_q <= vin && vvalid_q[vaddr];
		end
		if (cmd.exec) n_q <= rd_q;
	end

	smeu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(t_q), .divisor(n_q), .done(div_done), .quotient(quo)
	);
	assign stat.div_done = div_done;
	assign stat.is_div   = (item_q.kind == OP_DIV) && (err_q == ERR_OK);

	// Decode and error checks; n_q is the same cycle's read here via rd_q.
	logic [31:0] n_now, t_now;
	logic signed [31:0] st, sn;
	logic [63:0] prod;
	error_t e;
	logic   j;
	logic [31:0] r;
	assign n_now = rd_q;
	assign t_now = t_q;
	assign st = t_now;
	assign sn = n_now;
	assign prod = t_now * n_now;

	always_comb begin
		e = ERR_OK; j = 1'b0; r = '0;
		case (item_q.kind)
			OP_PUSH, OP_PUSHFROM: if (dcnt_q >= (DAW+1)'(DATA_DEPTH)) e = ERR_OVER;
			OP_DUP: begin
				if (dcnt_q < 1) e = ERR_UNDER;
				else if (dcnt_q >= (DAW+1)'(DATA_DEPTH)) e = ERR_OVER;
			end
			OP_JUMP: j = 1'b1;
			OP_JB, OP_JA, OP_JBE, OP_JAE, OP_JE, OP_JNE: begin
				if (dcnt_q < 2) e = ERR_UNDER;
				case (item_q.kind)
					OP_JB:   j = st > sn;
					OP_JA:   j = st < sn;
					OP_JBE:  j = st >= sn;
					OP_JAE:  j = st <= sn;
					OP_JE:   j = st == sn;
					default: j = st != sn;
				endcase
			end
			OP_CALL: begin
				if (rcnt_q >= (RAW+1)'(RETURN_DEPTH)) e = ERR_RET_FULL;
				j = 1'b1;
			end
			OP_RET: if (rcnt_q == 0) e = ERR_RET_EMPTY;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GE, OP_LE, OP_GT, OP_LT, OP_EQ,
			OP_NE: begin
				if (dcnt_q < 2) e = ERR_UNDER;
				else if (item_q.kind == OP_DIV && n_now == 0) e = ERR_DIV0;
				case (item_q.kind)
					OP_ADD:  r = t_now + n_now;
					OP_SUB:  r = t_now - n_now;
					OP_MUL:  r = prod[31:0];
					OP_GE:   r = {31'd0, sn >= st};
					OP_LE:   r = {31'd0, sn <= st};
					OP_GT:   r = {31'd0, sn > st};
					OP_LT:   r = {31'd0, sn < st};
					OP_EQ:   r = {31'd0, sn == st};
					OP_NE:   r = {31'd0, sn != st};
					default: r = '0;
				endcase
			end
			OP_TOP, OP_POP, OP_POPTO: if (dcnt_q < 1) e = ERR_UNDER;
			default: ;
		endcase
	end

	// Latch decision.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			err_q     <= e;
			jump_q    <= j;
			res_q     <= (item_q.kind == OP_PUSH) ? item_q.immediate :
			             (item_q.kind == OP_DUP) ? t_now :
			             (item_q.kind == OP_PUSHFROM) ? (vhit_q ? var_q : 32'd0) : r;
			wr_push_q <= (item_q.kind == OP_PUSH) || (item_q.kind == OP_DUP) ||
			             (item_q.kind == OP_PUSHFROM);
			wr_bin_q  <= (item_q.kind inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GE,
			             OP_LE, OP_GT, OP_LT, OP_EQ, OP_NE});
			pop_q     <= (item_q.kind == OP_POP) || (item_q.kind == OP_POPTO);
			popto_q   <= item_q.kind == OP_POPTO;
			call_q    <= item_q.kind == OP_CALL;
			ret_op_q  <= item_q.kind == OP_RET;
			clear_q   <= item_q.kind == OP_CLEAR;
		end else if (stat.is_div && div_done && !cmd.commit) begin
			res_q <= quo;
		end
	end

	// Next pc computed without wrap.
	logic [16:0] nx;
	assign nx = 17'(jump_q ? item_q.target : (ret_op_q ? ret_q : pc_q)) + 17'd1;

	always_ff @(posedge clk) begin
		if (cmd.commit && err_q == ERR_OK) begin
			if (wr_push_q) dstk[DAW'(dcnt_q)] <= res_q;
			else if (wr_bin_q) dstk[DAW'(dcnt_q - 2'd2)] <= res_q;
			if (call_q) rstk[RAW'(rcnt_q)] <= pc_q;
			if (popto_q && vin) vars[vaddr] <= t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; dcnt_q <= '0; rcnt_q <= '0; vvalid_q <= '0;
		end else if (cmd.commit && err_q == ERR_OK) begin
			pc_q <= (nx >= {1'b0, program_length}) ? 16'd0 : nx[15:0];
			if (clear_q) dcnt_q <= '0;
			else if (wr_push_q) dcnt_q <= dcnt_q + 1'b1;
			else if (wr_bin_q || pop_q) dcnt_q <= dcnt_q - 1'b1;
			if (call_q) rcnt_q <= rcnt_q + 1'b1;
			else if (ret_op_q) rcnt_q <= rcnt_q - 1'b1;
			if (popto_q && vin) vvalid_q[vaddr] <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= '0;
			if (err_q != ERR_OK) begin
				out_q.next_pc <= pc_q;
				out_q.error   <= err_q;
			end else begin
				out_q.halted  <= nx >= {1'b0, program_length};
				out_q.next_pc <= (nx >= {1'b0, program_length}) ? 16'd0 : nx[15:0];
				case (item_q.kind)
					OP_TOP:     begin out_q.action <= ACT_VALUE; out_q.value <= t_q; end
					OP_PRINT:   begin out_q.action <= ACT_TEXT;
					              out_q.text_out <= item_q.text_ref; end
					OP_NEWLINE: out_q.action <= ACT_NEWLINE;
					OP_SPACE:   out_q.action <= ACT_SPACE;
					OP_CLS:     out_q.action <= ACT_CLS;
					OP_GETCH:   out_q.action <= ACT_KEY;
					default:    ;
				endcase
			end
		end
	end
	assign out_item = out_q;
endmodule

@@ src/smeu_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
// Depends on smeu_pkg.
module smeu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  smeu_pkg::stat_t stat,
	output smeu_pkg::cmd_t  cmd
);
	import smeu_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nx = ST_READ;
			ST_READ:     state_nx = ST_EXEC;
			ST_EXEC:     state_nx = ST_DIV;
			ST_DIV:      state_nx = stat.is_div ? ST_DIV_WAIT : ST_WRITE;
			ST_DIV_WAIT: if (stat.div_done) state_nx = ST_WRITE;
			ST_WRITE:    state_nx = ST_OUT;
			ST_OUT:      if (!out_stall) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE:     begin in_stall = 1'b0; cmd.load = in_valid; end
			ST_READ:     cmd.read_n = 1'b1;
			ST_EXEC:     cmd.exec = 1'b1;
			ST_DIV:      cmd.div_start = stat.is_div;
			ST_DIV_WAIT: ;
			ST_WRITE:    cmd.commit = 1'b1;
			ST_OUT:      out_valid = 1'b1;
			default:     ;
		endcase
	end
endmodule

@@ src/stack_machine_execute_unit.sv @@
// Channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | smeu_pkg::in_item_t
// out     | output    | out_valid/out_stall| smeu_pkg::out_item_t
// cfg     | input     | cfg_we             | cfg_wdata (program length)
// An item steps through the idle (load), read, exec, div, write and out states; a divide
// also waits for the bit-serial divider. One item is in flight at a time.
// arst_n clears pc, stack counts, variable valid bits and the controller.
// A stalled result holds in the output register until taken.
module stack_machine_execute_unit #(
	parameter int DATA_DEPTH   = smeu_pkg::DataDepthDef,
	parameter int RETURN_DEPTH = smeu_pkg::ReturnDepthDef,
	parameter int VAR_COUNT    = smeu_pkg::VarCountDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  smeu_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output smeu_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);
	import smeu_pkg::*;

	cmd_t        cmd;
	stat_t       stat;
	logic [15:0] plen_q;

	// Program length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     plen_q <= '0;
		else if (cfg_we) plen_q <= cfg_wdata;
	end

	smeu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	smeu_datapath #(
		.DATA_DEPTH(DATA_DEPTH), .RETURN_DEPTH(RETURN_DEPTH), .VAR_COUNT(VAR_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_item(in_item),
		.program_length(plen_q), .out_item(out_item)
	);

	// An error result never reports a halt or an action.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error != ERR_OK |-> !out_item.halted &&
		out_item.action == ACT_NONE) else $error("error result not clean");

	// Input is never taken while a result is pending.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output");

	// A halted result always points back at address zero.
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.halted |-> out_item.next_pc == 16'd0)
		else $error("halt with nonzero pc");
endmodule

@@ bench/tb_stack_machine_execute_unit.sv @@
// Self-checking testbench for stack_machine_execute_unit: a scoreboard class
// predicts each result from its own copy of the machine state.
// Depends on smeu_pkg and the execute unit RTL.
module tb_stack_machine_execute_unit;
	import smeu_pkg::*;

	localparam int DataDepth   = DataDepthDef;
	localparam int ReturnDepth = ReturnDepthDef;
	localparam int VarCount    = VarCountDef;
	localparam int QuietLimit  = 3000;
	localparam int HoldCycles  = 400;

	// Predicts the machine and checks each result against the oldest prediction.
	class smeu_scoreboard;
		logic [15:0] prog_len;
		logic [15:0] pc;
		logic [31:0] dstk [DataDepth];
		int          dcnt;
		logic [15:0] rstk [ReturnDepth];
		int          rcnt;
		logic [31:0] vars [VarCount];
		out_item_t   expq [$];
		int          fails;

		function new();
			prog_len = 0;
			pc = 0;
			dcnt = 0;
			rcnt = 0;
			fails = 0;
			foreach (vars[i]) vars[i] = 0;
		endfunction

		function int pending();
			return expq.size();
		endfunction

		// Executes one instruction on the predicted state and queues its result.
		function void note_input(in_item_t it);
			logic [31:0] t, n, r, at, an, val;
			logic signed [31:0] st, sn;
			logic [15:0] base, txt;
			logic [16:0] nx;
			bit jmp;
			error_t err;
			action_t act;
			out_item_t e;
			opcode_t op;
			op = opcode_t'(it.kind);
			t = (dcnt >= 1) ? dstk[dcnt-1] : 32'd0;
			n = (dcnt >= 2) ? dstk[dcnt-2] : 32'd0;
			st = t;
			sn = n;
			base = pc;
			jmp = 0;
			err = ERR_OK;
			act = ACT_NONE;
			val = 0;
			txt = 0;
			r = 0;
			case (op)
				OP_PUSH, OP_DUP, OP_PUSHFROM: begin
					if (op == OP_DUP && dcnt < 1) err = ERR_UNDER;
					else if (dcnt >= DataDepth) err = ERR_OVER;
					else begin
						if (op == OP_PUSH) dstk[dcnt] = it.immediate;
						else if (op == OP_DUP) dstk[dcnt] = t;
						else dstk[dcnt] = (it.var_index < VarCount) ? vars[it.var_index] : 32'd0;
						dcnt++;
					end
				end
				OP_JUMP: jmp = 1;
				OP_JB, OP_JA, OP_JBE, OP_JAE, OP_JE, OP_JNE: begin
					if (dcnt < 2) err = ERR_UNDER;
					else case (op)
						OP_JB:   jmp = st > sn;
						OP_JA:   jmp = st < sn;
						OP_JBE:  jmp = st >= sn;
						OP_JAE:  jmp = st <= sn;
						OP_JE:   jmp = st == sn;
						default: jmp = st != sn;
					endcase
				end
				OP_CALL: begin
					if (rcnt >= ReturnDepth) err = ERR_RET_FULL;
					else begin
						rstk[rcnt] = pc;
						rcnt++;
						jmp = 1;
					end
				end
				OP_RET: begin
					if (rcnt == 0) err = ERR_RET_EMPTY;
					else begin
						rcnt--;
						base = rstk[rcnt];
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GE, OP_LE, OP_GT, OP_LT, OP_EQ, OP_NE: begin
					if (dcnt < 2) err = ERR_UNDER;
					else if (op == OP_DIV && n == 0) err = ERR_DIV0;
					else begin
						case (op)
							OP_ADD: r = t + n;
							OP_SUB: r = t - n;
							OP_MUL: r = t * n;
							OP_DIV: begin
								// Magnitude divide, so the most negative value wraps to itself.
								at = t[31] ? -t : t;
								an = n[31] ? -n : n;
								r = at / an;
								if (t[31] ^ n[31]) r = -r;
							end
							OP_GE:   r = {31'd0, sn >= st};
							OP_LE:   r = {31'd0, sn <= st};
							OP_GT:   r = {31'd0, sn > st};
							OP_LT:   r = {31'd0, sn < st};
							OP_EQ:   r = {31'd0, sn == st};
							default: r = {31'd0, sn != st};
						endcase
						dcnt--;
						dstk[dcnt-1] = r;
					end
				end
				OP_TOP: begin
					if (dcnt < 1) err = ERR_UNDER;
					else begin
						act = ACT_VALUE;
						val = t;
					end
				end
				OP_CLEAR: dcnt = 0;
				OP_POP, OP_POPTO: begin
					if (dcnt < 1) err = ERR_UNDER;
					else begin
						if (op == OP_POPTO && it.var_index < VarCount) vars[it.var_index] = t;
						dcnt--;
					end
				end
				OP_PRINT: begin
					act = ACT_TEXT;
					txt = it.text_ref;
				end
				OP_NEWLINE: act = ACT_NEWLINE;
				OP_SPACE:   act = ACT_SPACE;
				OP_CLS:     act = ACT_CLS;
				OP_GETCH:   act = ACT_KEY;
				default: ;
			endcase
			e = '0;
			if (err != ERR_OK) begin
				e.next_pc = pc;
				e.error = err;
			end else begin
				// The next address is formed one bit wider, so target 65535 halts.
				nx = {1'b0, jmp ? it.target : base} + 17'd1;
				if (nx >= {1'b0, prog_len}) begin
					nx = 0;
					e.halted = 1;
				end
				pc = nx[15:0];
				e.next_pc = nx[15:0];
				e.action = act;
				e.value = val;
				e.text_out = txt;
			end
			expq.push_back(e);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expq.size() == 0) begin
				$error("result item with nothing expected");
				fails++;
				return;
			end
			e = expq.pop_front();
			if (got.next_pc !== e.next_pc) begin
				$error("next_pc expected %0d actual %0d", e.next_pc, got.next_pc);
				fails++;
			end
			if (got.halted !== e.halted) begin
				$error("halted expected %0d actual %0d", e.halted, got.halted);
				fails++;
			end
			if (got.action !== e.action) begin
				$error("action expected %0d actual %0d", e.action, got.action);
				fails++;
			end
			if (got.value !== e.value) begin
				$error("value expected %0h actual %0h", e.value, got.value);
				fails++;
			end
			if (got.text_out !== e.text_out) begin
				$error("text_out expected %0h actual %0h", e.text_out, got.text_out);
				fails++;
			end
			if (got.error !== e.error) begin
				$error("error expected %0d actual %0d", e.error, got.error);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	smeu_scoreboard sb = new();
	bit calm = 1'b1;
	bit hold_tog = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int quiet = 0;

	stack_machine_execute_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offers one instruction item, with random gaps when not calm, until the block accepts it.
	task automatic send_item(in_item_t it);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic send_op(opcode_t op, logic [31:0] imm, logic [15:0] tgt, logic [5:0] vi);
		in_item_t it;
		it.kind = op;
		it.immediate = imm;
		it.target = tgt;
		it.var_index = vi;
		it.text_ref = 16'($urandom());
		send_item(it);
	endtask

	// Waits until the block has drained, then writes the program length.
	task automatic set_length(logic [15:0] len);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		sb.prog_len = len;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random instruction mix; pushes are favored so the stack stays populated.
	task automatic send_random(int count, int tgt_max, int push_pct);
		in_item_t it;
		int sel;
		repeat (count) begin
			it.kind = ($urandom_range(99) < push_pct) ? OP_PUSH : 5'($urandom());
			sel = $urandom_range(9);
			it.immediate = (sel == 0) ? 32'h8000_0000 : (sel == 1) ? 32'h7FFF_FFFF :
				(sel == 2) ? 32'd0 : (sel < 5) ? 32'($urandom_range(4)) - 2 : $urandom();
			it.target = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(tgt_max));
			it.var_index = 6'($urandom());
			it.text_ref = 16'($urandom());
			send_item(it);
		end
	endtask

	// Result side: checks accepted items and stalls at random or for one long hold.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) sb.check_result(out_item);
			@(negedge clk);
			if (hold_tog != hold_seen) begin
				hold_seen = hold_tog;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 31);
			end
		end
	end

	// Ends the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QuietLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_length(16'hFFFF);

		// Directed part: empty stack errors, wrap, divide corners, jumps and console.
		send_op(OP_POP, 0, 0, 0);
		send_op(OP_RET, 0, 0, 0);
		send_op(OP_DUP, 0, 0, 0);
		send_op(OP_PUSH, 32'hFFFF_FFFF, 0, 0);
		send_op(OP_PUSH, 32'h8000_0000, 0, 0);
		send_op(OP_DIV, 0, 0, 0);
		send_op(OP_PUSH, 32'd0, 0, 0);
		send_op(OP_PUSH, 32'd7, 0, 0);
		send_op(OP_DIV, 0, 0, 0);
		send_op(OP_PUSH, 32'h7FFF_FFFF, 0, 0);
		send_op(OP_ADD, 0, 0, 0);
		send_op(OP_MUL, 0, 0, 0);
		send_op(OP_TOP, 0, 0, 0);
		send_op(OP_DUP, 0, 0, 0);
		send_op(OP_GE, 0, 0, 0);
		send_op(OP_JB, 0, 16'd3, 0);
		send_op(OP_JNE, 0, 16'hFFFF, 0);
		send_op(OP_CALL, 0, 16'd20, 0);
		send_op(OP_RET, 0, 0, 0);
		send_op(OP_POPTO, 0, 0, 6'd63);
		send_op(OP_PUSHFROM, 0, 0, 6'd63);
		send_op(OP_PUSHFROM, 0, 0, 6'd0);
		send_op(OP_PRINT, 0, 0, 0);
		send_op(OP_NEWLINE, 0, 0, 0);
		send_op(OP_SPACE, 0, 0, 0);
		send_op(OP_CLS, 0, 0, 0);
		send_op(OP_GETCH, 0, 0, 0);
		send_op(OP_CLEAR, 0, 0, 0);
		send_op(OP_JUMP, 0, 16'hFFFF, 0);

		calm = 1'b0;
		send_random(25, 65535, 35);
		hold_tog = !hold_tog;
		send_random(15, 65535, 35);
		set_length(16'd40);
		send_random(15, 45, 35);
		set_length(16'd0);
		send_random(8, 10, 35);
		set_length(16'd1);
		send_random(7, 3, 35);
		set_length(16'hFFFF);

		// Fill the data stack past its depth, then the return stack.
		repeat (DataDepth + 2) send_op(($urandom_range(3) == 0) ? OP_DUP :
			($urandom_range(3) == 0) ? OP_PUSHFROM : OP_PUSH, $urandom(), 0,
			6'($urandom()));
		send_op(OP_DUP, 0, 0, 0);
		send_op(OP_PUSHFROM, 0, 0, 6'd5);
		send_op(OP_CLEAR, 0, 0, 0);
		repeat (ReturnDepth + 2) send_op(OP_CALL, 0, 16'($urandom_range(1000)), 0);
		repeat (4) send_op(OP_RET, 0, 0, 0);
		send_random(10, 65535, 35);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

@@ sim.f @@
src/smeu_pkg.sv
src/smeu_div.sv
src/smeu_datapath.sv
src/smeu_ctrl.sv
src/stack_machine_execute_unit.sv
bench/tb_stack_machine_execute_unit.sv
